[hw/rtl/lzs_pkg.sv]
// Shared types, codes and class tables of the LZ sequence symbolizer.
package lzs_pkg;

	localparam int REPEAT_SLOTS_DEF = 3;
	localparam int FIFO_DEPTH       = 2;
	localparam int LEN_CLASSES      = 29;

	localparam logic [1:0] OP_SEQ   = 2'd0;
	localparam logic [1:0] OP_LIT   = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;

	localparam logic [1:0] KIND_COUNT = 2'd0;
	localparam logic [1:0] KIND_LEN   = 2'd1;
	localparam logic [1:0] KIND_DIST  = 2'd2;
	localparam logic [1:0] KIND_BYTE  = 2'd3;

	localparam logic [2:0] ERR_OK       = 3'd0;
	localparam logic [2:0] ERR_FIRST    = 3'd1;
	localparam logic [2:0] ERR_NO_MATCH = 3'd2;
	localparam logic [2:0] ERR_LENGTH   = 3'd3;
	localparam logic [2:0] ERR_DIST     = 3'd4;

	localparam logic [1:0] REG_WINDOW = 2'd0;
	localparam logic [1:0] REG_MIN    = 2'd1;
	localparam logic [1:0] REG_MAX    = 2'd2;

	localparam logic [20:0] WINDOW_RST = 21'd32768;
	localparam logic [8:0]  MIN_RST    = 9'd3;
	localparam logic [8:0]  MAX_RST    = 9'd258;
	localparam logic [20:0] DIST_LIMIT = 21'd1048576;

	localparam logic [8:0] LEN_BASE [LEN_CLASSES] = '{
		9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
		9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
		9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258};
	localparam logic [8:0] LEN_LAST [LEN_CLASSES] = '{
		9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd12, 9'd14, 9'd16, 9'd18,
		9'd22, 9'd26, 9'd30, 9'd34, 9'd42, 9'd50, 9'd58, 9'd66, 9'd82, 9'd98, 9'd114,
		9'd130, 9'd162, 9'd194, 9'd226, 9'd257, 9'd258};
	localparam logic [2:0] LEN_BITS [LEN_CLASSES] = '{
		3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
		3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
		3'd5, 3'd5, 3'd5, 3'd5, 3'd0};

	typedef struct packed {
		logic [1:0]  kind;
		logic [8:0]  ctx;
		logic [7:0]  sym;
		logic [30:0] extra;
		logic [4:0]  cnt;
		logic [2:0]  err;
		logic        last;
	} token_t;

	typedef struct packed {
		logic [1:0]       ntok;
		token_t [2:0]     tok;
	} entry_t;

endpackage

[hw/rtl/lz_sequence_symbolizer_core.sv]
// Top level of the LZ sequence symbolizer: front end, token queue, back end.
// One item is accepted per cycle while the two-entry token queue has room. A
// literal byte or an error gives one token, a first sequence one token, a later
// sequence three (length, distance, literal count), and start or unused opcodes
// none; tokens leave one per cycle while m_tready is high, so a run of sequences
// is held back by the single result channel. Classification and all stream
// state updates happen in the cycle of the input transfer; a token reaches the
// result channel from the registered token queue. Configuration writes are
// always taken (cfg_ready is high) and apply to items accepted afterwards.
module lz_sequence_symbolizer_core #(
	parameter int REPEAT_SLOTS = lzs_pkg::REPEAT_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // length, distance, literal_count, literal_value
	input  logic [1:0]  s_tuser,   // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // context_res, symbol, extra bits, extra_count, error_code
	output logic [1:0]  m_tuser,   // token_kind
	output logic        m_tlast,   // last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [20:0] cfg_data
);

	logic            push, pop, full, empty, in_fire;
	lzs_pkg::entry_t wr_entry, head;
	lzs_pkg::token_t tok;

	assign s_tready = !full;
	assign cfg_ready = 1'b1;
	assign in_fire = s_tvalid && s_tready;

	lzs_front #(.REPEAT_SLOTS(REPEAT_SLOTS)) u_front (
		.clk, .arst_n,
		.cfg_valid, .cfg_index, .cfg_data,
		.in_fire,
		.opcode(s_tuser),
		.mlen(s_tdata[8:0]),
		.mdist(s_tdata[29:9]),
		.lcount(s_tdata[61:30]),
		.lbyte(s_tdata[69:62]),
		.push, .entry(wr_entry)
	);

	lzs_token_fifo u_fifo (
		.clk, .arst_n, .push, .wr_entry, .pop, .rd_entry(head), .full, .empty
	);

	lzs_back u_back (
		.clk, .arst_n, .head, .empty, .pop,
		.tvalid(m_tvalid), .tready(m_tready), .tok
	);

	assign m_tdata = {tok.err, tok.cnt, tok.extra, tok.sym, tok.ctx};
	assign m_tuser = tok.kind;
	assign m_tlast = tok.last;

endmodule

[hw/rtl/lzs_front.sv]
// Front end: accepts items, checks and classifies them, keeps stream state.
module lzs_front #(
	parameter int REPEAT_SLOTS = lzs_pkg::REPEAT_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [1:0]          cfg_index,
	input  logic [20:0]         cfg_data,
	input  logic                in_fire,
	input  logic [1:0]          opcode,
	input  logic [8:0]          mlen,
	input  logic [20:0]         mdist,
	input  logic [31:0]         lcount,
	input  logic [7:0]          lbyte,
	output logic                push,
	output lzs_pkg::entry_t     entry
);

	localparam int SLOT_W = (REPEAT_SLOTS > 1) ? $clog2(REPEAT_SLOTS) : 1;

	logic [20:0] window_q;
	logic [8:0]  min_q, max_q;
	logic [20:0] rep_q [REPEAT_SLOTS];
	logic [5:0]  count_ctx_q;
	logic [4:0]  len_ctx_q;
	logic [5:0]  dist_ctx_q;
	logic [8:0]  byte_ctx_q;
	logic        first_q;

	function automatic logic [4:0] msb32(input logic [31:0] v);
		logic [4:0] r;
		r = 5'd0;
		for (int i = 0; i < 32; i++)
			if (v[i]) r = 5'(i);
		return r;
	endfunction

	// length class
	logic [lzs_pkg::LEN_CLASSES-1:0] lhit, lbelow;
	logic        lfound;
	logic [4:0]  lsym;
	logic [8:0]  lbase;
	logic [2:0]  lbits;
	always_comb begin
		lbase = '0;
		lbits = '0;
		for (int j = 0; j < lzs_pkg::LEN_CLASSES; j++) begin
			lhit[j] = (mlen >= lzs_pkg::LEN_BASE[j]) && (mlen <= lzs_pkg::LEN_LAST[j]);
			lbelow[j] = (mlen > lzs_pkg::LEN_LAST[j]) && (lzs_pkg::LEN_LAST[j] >= min_q);
			if (lhit[j]) begin
				lbase = lbase | lzs_pkg::LEN_BASE[j];
				lbits = lbits | lzs_pkg::LEN_BITS[j];
			end
		end
		lfound = (mlen >= min_q) && (mlen <= max_q) && (|lhit);
		lsym = 5'($countones(lbelow));
	end

	// distance: repeat lanes, then class from the top bits of distance - 1
	logic                rhit;
	logic [SLOT_W-1:0]   rslot, kslot;
	logic [20:0]         dx;
	logic [4:0]          dt, db;
	logic [5:0]          didx;
	logic [20:0]         dextra;
	logic [4:0]          dbits;
	logic [7:0]          dsym;
	logic                dbad;
	always_comb begin
		rhit = 1'b0;
		rslot = '0;
		for (int i = REPEAT_SLOTS - 1; i >= 0; i--)
			if (rep_q[i] == mdist) begin
				rhit = 1'b1;
				rslot = SLOT_W'(i);
			end
		kslot = rhit ? rslot : SLOT_W'(REPEAT_SLOTS - 1);
		dbad = (mdist == 21'd0) || (mdist > window_q) || (mdist > lzs_pkg::DIST_LIMIT);
		dx = mdist - 21'd1;
		dt = msb32({11'd0, dx});
		db = dt - 5'd1;
		if (mdist <= 21'd4) begin
			didx = 6'(dx);
			dextra = '0;
			dbits = '0;
		end else begin
			didx = {dt, 1'b0} + {5'd0, dx[db]};
			dextra = dx & ((21'd1 << db) - 21'd1);
			dbits = db;
		end
		if (rhit) begin
			dsym = 8'(rslot);
			dextra = '0;
			dbits = '0;
		end else begin
			dsym = 8'(REPEAT_SLOTS) + {2'd0, didx};
		end
	end

	// literal count class
	logic [4:0]  ctop;
	logic [5:0]  csym;
	logic [30:0] cextra;
	logic [4:0]  cbits;
	always_comb begin
		ctop = msb32(lcount);
		if (lcount < 32'd2) begin
			csym = 6'(lcount);
			cextra = '0;
			cbits = '0;
		end else begin
			csym = {1'b0, ctop} + 6'd1;
			cextra = 31'(lcount ^ (32'd1 << ctop));
			cbits = ctop;
		end
	end

	logic [2:0] err;
	always_comb begin
		priority if (first_q && (mlen != 9'd0 || mdist != 21'd0)) err = lzs_pkg::ERR_FIRST;
		else if (first_q) err = lzs_pkg::ERR_OK;
		else if (mlen == 9'd0) err = lzs_pkg::ERR_NO_MATCH;
		else if (!lfound) err = lzs_pkg::ERR_LENGTH;
		else if (dbad) err = lzs_pkg::ERR_DIST;
		else err = lzs_pkg::ERR_OK;
	end

	lzs_pkg::token_t tcount;
	always_comb begin
		tcount = '{kind: lzs_pkg::KIND_COUNT, ctx: {3'd0, count_ctx_q}, sym: {2'd0, csym},
			extra: cextra, cnt: cbits, err: lzs_pkg::ERR_OK, last: 1'b1};
		entry = '0;
		push = 1'b0;
		unique case (opcode)
			lzs_pkg::OP_LIT: begin
				push = in_fire;
				entry.ntok = 2'd1;
				entry.tok[0] = '{kind: lzs_pkg::KIND_BYTE, ctx: byte_ctx_q, sym: lbyte,
					extra: '0, cnt: '0, err: lzs_pkg::ERR_OK, last: 1'b1};
			end
			lzs_pkg::OP_SEQ: begin
				push = in_fire;
				if (err != lzs_pkg::ERR_OK) begin
					entry.ntok = 2'd1;
					entry.tok[0] = '{kind: lzs_pkg::KIND_COUNT, ctx: '0, sym: '0, extra: '0,
						cnt: '0, err: err, last: 1'b1};
				end else if (first_q) begin
					entry.ntok = 2'd1;
					entry.tok[0] = tcount;
				end else begin
					entry.ntok = 2'd3;
					entry.tok[0] = '{kind: lzs_pkg::KIND_LEN, ctx: {4'd0, len_ctx_q},
						sym: {3'd0, lsym}, extra: 31'(mlen - lbase), cnt: {2'd0, lbits},
						err: lzs_pkg::ERR_OK, last: 1'b0};
					entry.tok[1] = '{kind: lzs_pkg::KIND_DIST, ctx: {3'd0, dist_ctx_q},
						sym: dsym, extra: 31'(dextra), cnt: dbits,
						err: lzs_pkg::ERR_OK, last: 1'b0};
					entry.tok[2] = tcount;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= lzs_pkg::WINDOW_RST;
			min_q <= lzs_pkg::MIN_RST;
			max_q <= lzs_pkg::MAX_RST;
			for (int i = 0; i < REPEAT_SLOTS; i++) rep_q[i] <= '0;
			count_ctx_q <= '0;
			len_ctx_q <= '0;
			dist_ctx_q <= '0;
			byte_ctx_q <= '0;
			first_q <= 1'b1;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					lzs_pkg::REG_WINDOW: window_q <= cfg_data;
					lzs_pkg::REG_MIN: min_q <= cfg_data[8:0];
					lzs_pkg::REG_MAX: max_q <= cfg_data[8:0];
					default: ;
				endcase
			end
			if (in_fire) begin
				unique case (opcode)
					lzs_pkg::OP_START: begin
						for (int i = 0; i < REPEAT_SLOTS; i++) rep_q[i] <= '0;
						count_ctx_q <= '0;
						len_ctx_q <= '0;
						dist_ctx_q <= '0;
						byte_ctx_q <= '0;
						first_q <= 1'b1;
					end
					lzs_pkg::OP_LIT: byte_ctx_q <= {1'b0, lbyte} + 9'd1;
					lzs_pkg::OP_SEQ: begin
						if (err == lzs_pkg::ERR_OK) begin
							count_ctx_q <= csym + 6'd1;
							first_q <= 1'b0;
							if (!first_q) begin
								len_ctx_q <= lsym + 5'd1;
								dist_ctx_q <= 6'(dsym) + 6'd1;
								rep_q[0] <= mdist;
								for (int i = 1; i < REPEAT_SLOTS; i++)
									if (SLOT_W'(i) <= kslot) rep_q[i] <= rep_q[i-1];
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

endmodule

[hw/rtl/lzs_token_fifo.sv]
// Short queue of classified items between front and back end.
module lzs_token_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lzs_pkg::entry_t     wr_entry,
	input  logic                pop,
	output lzs_pkg::entry_t     rd_entry,
	output logic                full,
	output logic                empty
);

	localparam int PW = (lzs_pkg::FIFO_DEPTH > 1) ? $clog2(lzs_pkg::FIFO_DEPTH) : 1;
	localparam int CW = $clog2(lzs_pkg::FIFO_DEPTH + 1);

	lzs_pkg::entry_t mem_q [lzs_pkg::FIFO_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(lzs_pkg::FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign rd_entry = mem_q[rd_q];

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(lzs_pkg::FIFO_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= nxt(wr_q);
			if (pop) rd_q <= nxt(rd_q);
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("fifo overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("fifo underflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(lzs_pkg::FIFO_DEPTH)) else $error("fifo count out of range");
`endif

endmodule

[hw/rtl/lzs_back.sv]
// Back end: steps through the tokens of the queue head, one per transfer.
module lzs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lzs_pkg::entry_t     head,
	input  logic                empty,
	output logic                pop,
	output logic                tvalid,
	input  logic                tready,
	output lzs_pkg::token_t     tok
);

	logic [1:0] idx_q;
	logic       done;

	assign tvalid = !empty;
	assign tok = head.tok[idx_q];
	assign done = (idx_q + 2'd1 == head.ntok);
	assign pop = tvalid && tready && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (tvalid && tready) begin
			idx_q <= done ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

[tb/lz_sequence_symbolizer_core_tb.sv]
// Self-checking testbench for lz_sequence_symbolizer_core: directed and random stream traffic, token scoreboard.
module lz_sequence_symbolizer_core_tb;

	typedef struct {
		logic [1:0]  op;
		logic [8:0]  mlen;
		logic [20:0] mdist;
		logic [31:0] lcount;
		logic [7:0]  lbyte;
	} seq_item_t;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [20:0] cfg_data;

	lz_sequence_symbolizer_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock: period 10
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// shadow of the block's registers and stream state
	int unsigned win_sz, min_len, max_len;
	int unsigned rep_dist [lzs_pkg::REPEAT_SLOTS_DEF];
	int unsigned cnt_ctx, len_ctx, dist_ctx, byte_ctx;
	bit          first_seq;

	seq_item_t        pending_q [$];
	lzs_pkg::token_t  token_q [$];
	int               fail_cnt;
	int               tok_seen;
	int               items_sent;
	int               err_seen [5];
	int unsigned      recent_dist [4];

	// ---------------- token predictor ----------------
	task automatic push_tok(logic [1:0] kind, int unsigned ctx, int unsigned sym,
			int unsigned extra, int unsigned cnt, logic [2:0] err, bit lst);
		lzs_pkg::token_t t;
		t.kind  = kind;
		t.ctx   = ctx[8:0];
		t.sym   = sym[7:0];
		t.extra = extra[30:0];
		t.cnt   = cnt[4:0];
		t.err   = err;
		t.last  = lst;
		token_q.insert(token_q.size(), t);
	endtask

	task automatic predict_tokens(seq_item_t it);
		int unsigned mlen, mdist, lcnt;
		int unsigned lsym, lidx, dsym, dextra, dbits, idx, b, s, eb, top, k;
		bit          lfound, dfound;
		mlen  = it.mlen;
		mdist = it.mdist;
		lcnt  = it.lcount;
		case (it.op)
			lzs_pkg::OP_START: begin
				foreach (rep_dist[i]) rep_dist[i] = 0;
				cnt_ctx = 0; len_ctx = 0; dist_ctx = 0; byte_ctx = 0;
				first_seq = 1;
				return;
			end
			lzs_pkg::OP_LIT: begin
				push_tok(lzs_pkg::KIND_BYTE, byte_ctx, it.lbyte, 0, 0, lzs_pkg::ERR_OK, 1);
				byte_ctx = it.lbyte + 1;
				return;
			end
			lzs_pkg::OP_SEQ: ;
			default: return;
		endcase
		if (first_seq) begin
			if (mlen != 0 || mdist != 0) begin
				push_tok(lzs_pkg::KIND_COUNT, 0, 0, 0, 0, lzs_pkg::ERR_FIRST, 1);
				err_seen[lzs_pkg::ERR_FIRST]++;
				return;
			end
		end else begin
			if (mlen == 0) begin
				push_tok(lzs_pkg::KIND_COUNT, 0, 0, 0, 0, lzs_pkg::ERR_NO_MATCH, 1);
				err_seen[lzs_pkg::ERR_NO_MATCH]++;
				return;
			end
			lsym = 0; lidx = 0; lfound = 0;
			if (mlen >= min_len && mlen <= max_len) begin
				for (int i = 0; i < lzs_pkg::LEN_CLASSES; i++) begin
					if (lzs_pkg::LEN_BASE[i] > max_len || lzs_pkg::LEN_LAST[i] < min_len)
						continue;
					if (mlen >= lzs_pkg::LEN_BASE[i] && mlen <= lzs_pkg::LEN_LAST[i]) begin
						lidx = i; lfound = 1;
						break;
					end
					lsym++;
				end
			end
			if (!lfound) begin
				push_tok(lzs_pkg::KIND_COUNT, 0, 0, 0, 0, lzs_pkg::ERR_LENGTH, 1);
				err_seen[lzs_pkg::ERR_LENGTH]++;
				return;
			end
			if (mdist == 0 || mdist > win_sz || mdist > lzs_pkg::DIST_LIMIT) begin
				push_tok(lzs_pkg::KIND_COUNT, 0, 0, 0, 0, lzs_pkg::ERR_DIST, 1);
				err_seen[lzs_pkg::ERR_DIST]++;
				return;
			end
			dsym = 0; dextra = 0; dbits = 0; dfound = 0;
			for (int i = 0; i < lzs_pkg::REPEAT_SLOTS_DEF; i++)
				if (!dfound && rep_dist[i] == mdist) begin
					dsym = i; dfound = 1;
				end
			if (!dfound) begin
				idx = 0;
				for (int i = 0; i < 40; i++) begin
					if (i < 4) begin
						b = i + 1; s = 1; eb = 0;
					end else begin
						eb = i / 2 - 1;
						s  = 1 << eb;
						b  = 1 + (2 << eb) + ((i & 1) ? (1 << eb) : 0);
					end
					if (b > win_sz) continue;
					if (mdist >= b && mdist <= b + s - 1) begin
						dsym = lzs_pkg::REPEAT_SLOTS_DEF + idx; dextra = mdist - b; dbits = eb;
						break;
					end
					idx++;
				end
			end
			push_tok(lzs_pkg::KIND_LEN, len_ctx, lsym, mlen - lzs_pkg::LEN_BASE[lidx],
				lzs_pkg::LEN_BITS[lidx], lzs_pkg::ERR_OK, 0);
			len_ctx = lsym + 1;
			push_tok(lzs_pkg::KIND_DIST, dist_ctx, dsym, dextra, dbits, lzs_pkg::ERR_OK, 0);
			dist_ctx = dsym + 1;
			// move-to-front of the repeat list
			k = lzs_pkg::REPEAT_SLOTS_DEF - 1;
			for (int i = lzs_pkg::REPEAT_SLOTS_DEF - 1; i >= 0; i--)
				if (rep_dist[i] == mdist) k = i;
			for (int i = k; i > 0; i--) rep_dist[i] = rep_dist[i - 1];
			rep_dist[0] = mdist;
		end
		if (lcnt < 2) begin
			push_tok(lzs_pkg::KIND_COUNT, cnt_ctx, lcnt, 0, 0, lzs_pkg::ERR_OK, 1);
			cnt_ctx = lcnt + 1;
		end else begin
			top = 31;
			while (((lcnt >> top) & 1) == 0) top--;
			push_tok(lzs_pkg::KIND_COUNT, cnt_ctx, top + 1, lcnt - (1 << top), top,
				lzs_pkg::ERR_OK, 1);
			cnt_ctx = top + 2;
		end
		first_seq = 0;
	endtask

	// ---------------- input driver ----------------
	int burst_left, gap_left;

	always @(posedge clk or negedge arst_n) begin
		seq_item_t cur;
		bit        drive;
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tuser    <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			drive = 0;
			if (s_tvalid && s_tready) begin
				predict_tokens(pending_q.pop_front());
				items_sent++;
			end
			if (s_tvalid && !s_tready) begin
				drive = 1;
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
			end else if (pending_q.size() > 0) begin
				drive = 1;
				if (burst_left > 0) begin
					burst_left <= burst_left - 1;
				end else begin
					// end of burst: pick next burst length and the gap after it
					burst_left <= $urandom_range(0, 15);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
			if (drive && pending_q.size() > 0) begin
				cur = pending_q[0];
				s_tdata <= {2'b00, cur.lbyte, cur.lcount, cur.mdist, cur.mlen};
				s_tuser <= cur.op;
			end
			s_tvalid <= drive && pending_q.size() > 0;
		end
	end

	// ---------------- output monitor ----------------
	int stall_mode, mode_cnt;

	always @(posedge clk or negedge arst_n) begin
		lzs_pkg::token_t got, want;
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_mode <= 0;
			mode_cnt   <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.kind  = m_tuser;
				got.ctx   = m_tdata[8:0];
				got.sym   = m_tdata[16:9];
				got.extra = m_tdata[47:17];
				got.cnt   = m_tdata[52:48];
				got.err   = m_tdata[55:53];
				got.last  = m_tlast;
				tok_seen++;
				if (token_q.size() == 0) begin
					$display("%0t: unexpected token kind=%0d ctx=%0d sym=%0d extra=%0d cnt=%0d err=%0d last=%0d",
						$time, got.kind, got.ctx, got.sym, got.extra, got.cnt, got.err, got.last);
					fail_cnt++;
				end else begin
					want = token_q.pop_front();
					if (got.kind !== want.kind || got.ctx !== want.ctx || got.sym !== want.sym ||
							got.extra !== want.extra || got.cnt !== want.cnt ||
							got.err !== want.err || got.last !== want.last) begin
						$display("%0t: token mismatch exp kind=%0d ctx=%0d sym=%0d extra=%0d cnt=%0d err=%0d last=%0d",
							$time, want.kind, want.ctx, want.sym, want.extra, want.cnt, want.err,
							want.last);
						$display("%0t:                got kind=%0d ctx=%0d sym=%0d extra=%0d cnt=%0d err=%0d last=%0d",
							$time, got.kind, got.ctx, got.sym, got.extra, got.cnt, got.err, got.last);
						fail_cnt++;
					end
				end
			end
			// backpressure: mode changes when mode_cnt wraps, none / light / heavy / toggling
			if (mode_cnt == 49) begin
				mode_cnt   <= 0;
				stall_mode <= $urandom_range(0, 3);
			end else begin
				mode_cnt <= mode_cnt + 1;
			end
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 99) >= 25);
				2: m_tready <= ($urandom_range(0, 99) >= 75);
				default: m_tready <= mode_cnt[1];
			endcase
		end
	end

	// ---------------- watchdog ----------------
	int idle_cycles;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d tokens outstanding", $time, token_q.size());
			$display("FAIL");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	task automatic write_reg(logic [1:0] idx, int unsigned val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[20:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			lzs_pkg::REG_WINDOW: win_sz  = val[20:0];
			lzs_pkg::REG_MIN:    min_len = val[8:0];
			default:             max_len = val[8:0];
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(int unsigned w, int unsigned lo, int unsigned hi);
		write_reg(lzs_pkg::REG_WINDOW, w);
		write_reg(lzs_pkg::REG_MIN, lo);
		write_reg(lzs_pkg::REG_MAX, hi);
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending_q.size() > 0 || s_tvalid || token_q.size() > 0) @(posedge clk);
		// start items leave nothing to wait on; cover the pipeline anyway
		repeat (6) @(posedge clk);
	endtask

	task automatic add(logic [1:0] op, int unsigned len, int unsigned dst,
			logic [31:0] cnt, logic [7:0] lb);
		seq_item_t it;
		it.op = op; it.mlen = len[8:0]; it.mdist = dst[20:0]; it.lcount = cnt; it.lbyte = lb;
		pending_q.insert(pending_q.size(), it);
	endtask

	function automatic logic [31:0] rand_count();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 3);
			1: return $urandom_range(0, 300);
			2: return 32'd1 << $urandom_range(0, 31);
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic int unsigned rand_dist();
		int unsigned wmax;
		wmax = (win_sz > lzs_pkg::DIST_LIMIT) ? lzs_pkg::DIST_LIMIT : win_sz;
		if (wmax == 0) return $urandom_range(1, 40);
		case ($urandom_range(0, 3))
			0: return recent_dist[$urandom_range(0, 3)] % wmax + 1;
			1: return $urandom_range(1, (wmax < 64) ? wmax : 64);
			2: return wmax;
			default: return $urandom_range(1, wmax);
		endcase
	endfunction

	// one well-formed stream: start, clean first sequence, then matches and bytes
	task automatic add_stream(int n);
		int unsigned d;
		add(lzs_pkg::OP_START, $urandom_range(0, 258), $urandom_range(0, 1048576), $urandom,
			$urandom);
		add(lzs_pkg::OP_SEQ, 0, 0, rand_count(), $urandom);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				add(lzs_pkg::OP_LIT, $urandom_range(0, 258), $urandom_range(0, 1048576), $urandom,
					$urandom);
			end else begin
				d = rand_dist();
				recent_dist[$urandom_range(0, 3)] = d;
				add(lzs_pkg::OP_SEQ, (min_len <= max_len) ? $urandom_range(min_len, max_len) : 3,
					d, rand_count(), $urandom);
			end
		end
	endtask

	task automatic add_noise(int n);
		for (int i = 0; i < n; i++)
			add($urandom_range(0, 3), $urandom_range(0, 258), $urandom_range(0, 1048576),
				rand_count(), $urandom);
	endtask

	task automatic random_phase(int n);
		while (n > 0) begin
			if ($urandom_range(0, 4) == 0) begin
				add_noise(4); n -= 4;
			end else begin
				add_stream(8); n -= 10;
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		m_tready  = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		fail_cnt  = 0;
		tok_seen  = 0;
		items_sent = 0;
		idle_cycles = 0;
		foreach (err_seen[i]) err_seen[i] = 0;
		foreach (recent_dist[i]) recent_dist[i] = i * 7 + 1;
		win_sz = lzs_pkg::WINDOW_RST; min_len = lzs_pkg::MIN_RST; max_len = lzs_pkg::MAX_RST;
		foreach (rep_dist[i]) rep_dist[i] = 0;
		cnt_ctx = 0; len_ctx = 0; dist_ctx = 0; byte_ctx = 0; first_seq = 1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, reset configuration
		add(lzs_pkg::OP_SEQ, 3, 1, 0, 0);             // match on first sequence
		add(lzs_pkg::OP_SEQ, 0, 0, 1, 0);             // clean first
		add(lzs_pkg::OP_SEQ, 0, 0, 2, 0);             // missing match
		add(lzs_pkg::OP_SEQ, 2, 1, 0, 0);             // length below every class
		add(lzs_pkg::OP_SEQ, 258, 0, 0, 0);           // distance zero
		add(lzs_pkg::OP_SEQ, 258, 32769, 0, 0);       // distance past window
		add(lzs_pkg::OP_SEQ, 3, 1, 32'hFFFF_FFFF, 8'hFF);
		add(lzs_pkg::OP_SEQ, 258, 32768, 32'h8000_0000, 0);
		add(lzs_pkg::OP_SEQ, 257, 32768, 3, 0);       // repeat hit slot 0
		add(lzs_pkg::OP_SEQ, 10, 1, 0, 0);            // repeat hit slot 1
		add(lzs_pkg::OP_SEQ, 11, 5, 1, 0);            // new distance, not in the repeat list
		add(lzs_pkg::OP_LIT, 0, 0, 0, 8'h00);
		add(lzs_pkg::OP_LIT, 0, 0, 0, 8'hFF);
		add(OP_UNUSED, 258, 1048576, 32'hFFFF_FFFF, 8'hFF);
		add(lzs_pkg::OP_START, 0, 0, 0, 0);
		add(lzs_pkg::OP_LIT, 0, 0, 0, 8'h5A);
		add(lzs_pkg::OP_SEQ, 0, 0, 0, 0);
		add(lzs_pkg::OP_SEQ, 227, 4, 5, 0);
		drain();

		set_config(lzs_pkg::DIST_LIMIT, 3, 258);      // widest window
		add(lzs_pkg::OP_START, 0, 0, 0, 0);
		add(lzs_pkg::OP_SEQ, 0, 0, 7, 0);
		add(lzs_pkg::OP_SEQ, 258, 1048576, 9, 0);
		add(lzs_pkg::OP_SEQ, 3, 786433, 9, 0);
		random_phase(70);
		drain();

		set_config(1, 258, 258);             // narrowest setting
		random_phase(50);
		drain();

		set_config(300, 10, 50);
		random_phase(70);
		drain();

		set_config(5000, 100, 20);           // min above max: every later match rejected
		random_phase(30);
		drain();

		for (int p = 0; p < 3; p++) begin
			set_config($urandom_range(1, 1048576), $urandom_range(3, 40),
				$urandom_range(40, 258));
			random_phase(40);
			drain();
		end

		set_config(lzs_pkg::WINDOW_RST, lzs_pkg::MIN_RST, lzs_pkg::MAX_RST);
		random_phase(20);
		drain();
		repeat (10) @(posedge clk);

		$display("Sent %0d items, checked %0d tokens across 9 register settings.",
			items_sent, tok_seen);
		$display("Errors seen: first=%0d no_match=%0d length=%0d distance=%0d",
			err_seen[lzs_pkg::ERR_FIRST], err_seen[lzs_pkg::ERR_NO_MATCH],
			err_seen[lzs_pkg::ERR_LENGTH], err_seen[lzs_pkg::ERR_DIST]);
		if (fail_cnt == 0 && token_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches, %0d tokens never arrived", fail_cnt, token_q.size());
			$display("FAIL");
		end
		$finish;
	end

endmodule
